// ===== hw/rtl/b2b_pkg.sv =====
// Package: shared constants, types and lookup functions for the BLAKE2b core.
`timescale 1ns / 1ps
`default_nettype none
package b2b_pkg;
	localparam int BlockWordsDef = 16;
	localparam logic [63:0] ParamMix = 64'h0000_0000_0101_0000;
	localparam logic [63:0] FinalFlag = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [4:0] DefaultRounds = 5'd12;
	localparam logic [6:0] DigestMax = 7'd64;
	localparam int CfgIdxW = 8;

	typedef enum logic [2:0] {
		ST_IDLE, ST_BYTE, ST_PAD, ST_CINIT, ST_MIX, ST_CFIN, ST_EMIT
	} state_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ROUNDS  = 8'd0,
		CFG_DIGEST  = 8'd1,
		CFG_SALT_LO = 8'd2,
		CFG_SALT_HI = 8'd3
	} cfg_reg_t;

	// Control for the shared mixing unit.
	typedef struct packed {
		logic cb_line;   // 0: a/d update, 1: c/b update
		logic late_half; // second half of G
	} gstep_ctl_t;

	localparam logic [3:0] SIGMA [10][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

	localparam logic [3:0] LANE [8][4] = '{
		'{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
		'{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15},
		'{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
		'{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}
	};

	function automatic logic [63:0] iv_word(input logic [2:0] k);
		logic [63:0] r;
		case (k)
			3'd0: r = 64'h6A09E667F3BCC908;
			3'd1: r = 64'hBB67AE8584CAA73B;
			3'd2: r = 64'h3C6EF372FE94F82B;
			3'd3: r = 64'hA54FF53A5F1D36F1;
			3'd4: r = 64'h510E527FADE682D1;
			3'd5: r = 64'h9B05688C2B3E6C1F;
			3'd6: r = 64'h1F83D9ABFB41BD6B;
			default: r = 64'h5BE0CD19137E2179;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] sigma(input logic [3:0] row, input logic [3:0] pos);
		logic [3:0] r;
		r = (row > 4'd9) ? 4'd0 : SIGMA[row][pos];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/b2b_if.sv =====
// Interfaces: message, digest and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface b2b_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] message_word;
	logic [3:0]  byte_count;
	logic        final_word;
	modport source (output valid, message_word, byte_count, final_word, input ready);
	modport sink (input valid, message_word, byte_count, final_word, output ready);
endinterface

interface b2b_dig_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [3:0]  digest_valid_bytes;
	logic        last_digest_word;
	modport source (output valid, digest_word, digest_valid_bytes, last_digest_word,
		input ready);
	modport sink (input valid, digest_word, digest_valid_bytes, last_digest_word,
		output ready);
endinterface

interface b2b_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/b2b_gstep.sv =====
// Shared mixing unit: one quarter of the G function (one a/d or c/b update) per cycle.
`timescale 1ns / 1ps
`default_nettype none
module b2b_gstep
	import b2b_pkg::*;
(
	input  wire gstep_ctl_t  ctl,
	input  wire logic [63:0] x,   // a or c
	input  wire logic [63:0] y,   // b or d
	input  wire logic [63:0] z,   // d or b
	input  wire logic [63:0] m,
	output logic [63:0] x_new,
	output logic [63:0] z_new
);
	logic [63:0] t;
	always_comb begin
		x_new = x + y + (ctl.cb_line ? 64'd0 : m);
		t = z ^ x_new;
		case ({ctl.late_half, ctl.cb_line})
			2'b00: z_new = {t[31:0], t[63:32]};
			2'b01: z_new = {t[23:0], t[63:24]};
			2'b10: z_new = {t[15:0], t[63:16]};
			default: z_new = {t[62:0], t[63]};
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/blake2b_hash_core_top.sv =====
// Top level: BLAKE2b hash core with sequencer, state and block buffer.
// Flow: a message word is written into the block buffer byte by byte before the next beat
// is accepted; a full block spills through one compression, one G line per cycle in the
// shared mixing unit. The final word adds zero padding of the block, one compression
// and the digest beats. One item at a time.
// Reset: asynchronous, active low; config to defaults, chain value rebuilt at the next clock.
`timescale 1ns / 1ps
`default_nettype none
module blake2b_hash_core_top
	import b2b_pkg::*;
#(
	parameter int BLOCK_WORDS = BlockWordsDef
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	b2b_msg_if.sink    msg,
	b2b_dig_if.source  digest,
	b2b_cfg_if.sink    cfg
);
	localparam int BlockBytes = BLOCK_WORDS * 8;
	localparam int FillW = $clog2(BlockBytes + 1);
	localparam int AddrW = $clog2(BLOCK_WORDS);
	localparam logic [FillW-1:0] FillFull = FillW'(BlockBytes);

	// Configuration registers
	logic [4:0]  round_count_q;
	logic [6:0]  digest_bytes_q;
	logic [63:0] salt_low_q, salt_high_q;
	logic        reinit_q;

	// Sequencer
	state_t state_q, state_d;
	logic [63:0] word_q;
	logic [3:0]  cnt_q, bi_q;
	logic        fin_q, last_blk_q;
	logic [4:0]  round_q;
	logic [3:0]  row_q;
	logic [2:0]  g_q;
	logic [1:0]  step_q;
	logic [2:0]  k_q;

	// Hash state
	logic [63:0] h_q [8];
	logic [63:0] v_q [16];
	logic [63:0] buf_q [BLOCK_WORDS];
	logic [FillW-1:0] fill_q;
	logic [63:0] cnt_lo_q, cnt_hi_q;

	logic [4:0]  rounds_eff;
	logic [6:0]  dlen;
	logic [63:0] h_init [8];
	logic        msg_beat, dig_beat, do_init, mix_done;

	assign rounds_eff = (round_count_q == 5'd0) ? DefaultRounds : round_count_q;
	assign dlen = (digest_bytes_q == 7'd0) ? 7'd1 :
		((digest_bytes_q > DigestMax) ? DigestMax : digest_bytes_q);

	// Initial chain value from current configuration.
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			h_init[k] = iv_word(3'(k));
		end
		h_init[0] = h_init[0] ^ ParamMix ^ {57'd0, dlen};
		h_init[4] = h_init[4] ^ salt_low_q;
		h_init[5] = h_init[5] ^ salt_high_q;
	end

	assign cfg.ready = 1'b1;
	assign msg.ready = (state_q == ST_IDLE) && !reinit_q;
	assign msg_beat = msg.valid && msg.ready;
	assign dig_beat = digest.valid && digest.ready;

	// Digest output, read straight from the settled chain value.
	logic [6:0] rem_bytes;
	logic [2:0] last_k;
	logic [3:0] vb;
	always_comb begin
		rem_bytes = dlen - {1'b0, k_q, 3'b000};
		last_k = 3'((dlen - 7'd1) >> 3);
		vb = (rem_bytes > 7'd8) ? 4'd8 : rem_bytes[3:0];
		for (int j = 0; j < 8; j++) begin
			digest.digest_word[j*8 +: 8] = (4'(j) < vb) ? h_q[k_q][j*8 +: 8] : 8'd0;
		end
	end
	assign digest.valid = (state_q == ST_EMIT);
	assign digest.digest_valid_bytes = vb;
	assign digest.last_digest_word = (k_q == last_k);

	assign do_init = reinit_q || (dig_beat && digest.last_digest_word);
	assign mix_done = (step_q == 2'd3) && (g_q == 3'd7) && (round_q == rounds_eff - 5'd1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (msg_beat) state_d = ST_BYTE;
			end
			ST_BYTE: begin
				if (bi_q == cnt_q) state_d = fin_q ? ST_PAD : ST_IDLE;
				else if (fill_q == FillFull) state_d = ST_CINIT;
			end
			ST_PAD: begin
				if (fill_q == FillFull) state_d = ST_CINIT;
			end
			ST_CINIT: state_d = ST_MIX;
			ST_MIX: begin
				if (mix_done) state_d = ST_CFIN;
			end
			ST_CFIN: state_d = last_blk_q ? ST_EMIT : ST_BYTE;
			ST_EMIT: begin
				if (dig_beat && digest.last_digest_word) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; any known register forces a chain rebuild.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q  <= DefaultRounds;
			digest_bytes_q <= DigestMax;
			salt_low_q     <= '0;
			salt_high_q    <= '0;
			reinit_q       <= 1'b1;
		end else begin
			reinit_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ROUNDS: begin
						round_count_q <= cfg.data[4:0];
						reinit_q <= 1'b1;
					end
					CFG_DIGEST: begin
						digest_bytes_q <= cfg.data[6:0];
						reinit_q <= 1'b1;
					end
					CFG_SALT_LO: begin
						salt_low_q <= cfg.data;
						reinit_q <= 1'b1;
					end
					CFG_SALT_HI: begin
						salt_high_q <= cfg.data;
						reinit_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Fill level and 128-bit byte counter (upper half wraps).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			cnt_lo_q <= '0;
			cnt_hi_q <= '0;
		end else if (do_init) begin
			fill_q   <= '0;
			cnt_lo_q <= '0;
			cnt_hi_q <= '0;
		end else begin
			case (state_q)
				ST_BYTE: begin
					if (bi_q == cnt_q) begin
						if (fin_q) begin
							{cnt_hi_q, cnt_lo_q} <= {cnt_hi_q, cnt_lo_q} +
								{64'd0, {(64-FillW){1'b0}}, fill_q};
						end
					end else if (fill_q == FillFull) begin
						{cnt_hi_q, cnt_lo_q} <= {cnt_hi_q, cnt_lo_q} +
							{64'd0, {(64-FillW){1'b0}}, FillFull};
						fill_q <= '0;
					end else begin
						fill_q <= fill_q + FillW'(1);
					end
				end
				ST_PAD: begin
					if (fill_q != FillFull) fill_q <= fill_q + FillW'(1);
				end
				default: ;
			endcase
		end
	end

	// Control counters of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bi_q <= '0; cnt_q <= '0; fin_q <= 1'b0; last_blk_q <= 1'b0;
			round_q <= '0; row_q <= '0; g_q <= '0; step_q <= '0; k_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_beat) begin
						bi_q <= '0;
						cnt_q <= (msg.byte_count > 4'd8) ? 4'd8 : msg.byte_count;
						fin_q <= msg.final_word;
					end
				end
				ST_BYTE: begin
					if (bi_q != cnt_q && fill_q == FillFull) last_blk_q <= 1'b0;
					else if (bi_q != cnt_q) bi_q <= bi_q + 4'd1;
				end
				ST_PAD: begin
					if (fill_q == FillFull) last_blk_q <= 1'b1;
				end
				ST_CINIT: begin
					round_q <= '0; row_q <= '0; g_q <= '0; step_q <= '0;
				end
				ST_MIX: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						g_q <= g_q + 3'd1;
						if (g_q == 3'd7) begin
							round_q <= round_q + 5'd1;
							row_q <= (row_q == 4'd9) ? 4'd0 : row_q + 4'd1;
						end
					end
				end
				ST_CFIN: k_q <= '0;
				ST_EMIT: begin
					if (dig_beat) k_q <= k_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	// Message capture and block buffer byte writes.
	always_ff @(posedge clk) begin
		if (msg_beat) word_q <= msg.message_word;
		if (state_q == ST_BYTE && bi_q != cnt_q && fill_q != FillFull) begin
			buf_q[fill_q[3 +: AddrW]][{fill_q[2:0], 3'b000} +: 8] <=
				word_q[{bi_q[2:0], 3'b000} +: 8];
		end
		if (state_q == ST_PAD && fill_q != FillFull) begin
			buf_q[fill_q[3 +: AddrW]][{fill_q[2:0], 3'b000} +: 8] <= 8'd0;
		end
	end

	// Shared mixing unit: select lane operands for this step.
	gstep_ctl_t  gctl;
	logic [3:0]  ia, ib, ic, id, ix, iy, iz;
	logic [63:0] m_word, x_new, z_new;
	always_comb begin
		gctl.cb_line = step_q[0];
		gctl.late_half = step_q[1];
		ia = LANE[g_q][0];
		ib = LANE[g_q][1];
		ic = LANE[g_q][2];
		id = LANE[g_q][3];
		ix = gctl.cb_line ? ic : ia;
		iy = gctl.cb_line ? id : ib;
		iz = gctl.cb_line ? ib : id;
		m_word = buf_q[AddrW'(sigma(row_q, {g_q, step_q[1]}))];
	end

	b2b_gstep u_gstep (
		.ctl   (gctl),
		.x     (v_q[ix]),
		.y     (v_q[iy]),
		.z     (v_q[iz]),
		.m     (m_word),
		.x_new (x_new),
		.z_new (z_new)
	);

	// Working vector and chain value.
	always_ff @(posedge clk) begin
		if (do_init) begin
			for (int k = 0; k < 8; k++) h_q[k] <= h_init[k];
		end else if (state_q == ST_CFIN) begin
			for (int k = 0; k < 8; k++) h_q[k] <= h_q[k] ^ v_q[k] ^ v_q[k+8];
		end
		case (state_q)
			ST_CINIT: begin
				for (int k = 0; k < 8; k++) begin
					v_q[k] <= h_q[k];
					v_q[k+8] <= iv_word(3'(k));
				end
				v_q[12] <= iv_word(3'd4) ^ cnt_lo_q;
				v_q[13] <= iv_word(3'd5) ^ cnt_hi_q;
				v_q[14] <= iv_word(3'd6) ^ (last_blk_q ? FinalFlag : 64'd0);
			end
			ST_MIX: begin
				v_q[ix] <= x_new;
				v_q[iz] <= z_new;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/b2b_chk.sv =====
// Checker: port-level properties of the hash core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module b2b_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        msg_ready,
	input wire logic        dig_valid,
	input wire logic        dig_ready,
	input wire logic [63:0] dig_word,
	input wire logic [3:0]  dig_bytes,
	input wire logic        dig_last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig_word) && $stable(dig_bytes))
		else $error("digest beat dropped or changed while stalled");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> !msg_ready)
		else $error("input taken while digest pending");
	a_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> dig_bytes != 4'd0 && dig_bytes <= 4'd8)
		else $error("digest byte count out of range");
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_bytes != 4'd8 |-> dig_last)
		else $error("short digest beat not last");
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && !dig_last |=> dig_valid)
		else $error("digest burst interrupted");
endmodule

bind blake2b_hash_core_top b2b_chk u_b2b_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_ready (msg.ready),
	.dig_valid (digest.valid),
	.dig_ready (digest.ready),
	.dig_word  (digest.digest_word),
	.dig_bytes (digest.digest_valid_bytes),
	.dig_last  (digest.last_digest_word)
);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the BLAKE2b hash core top level.
`timescale 1ns / 1ps
module tb;
	import b2b_pkg::*;

	// One digest beat as seen on the result channel.
	typedef struct packed {
		bit [63:0] word;
		bit [3:0]  nbytes;
		bit        last;
	} digest_beat_t;

	localparam bit [63:0] CHAIN_IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	localparam int MSG_PERM [10][16] = '{
		'{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
		'{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
		'{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
		'{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
		'{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
		'{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
		'{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
		'{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
		'{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
		'{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
	};

	localparam int MIX_LANE [8][4] = '{
		'{0, 4,  8, 12}, '{1, 5,  9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
		'{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7,  8, 13}, '{3, 4,  9, 14}
	};

	localparam int DRAIN_CYCLES = 1300;

	// Hash predictor plus the queue of digest beats still owed by the core.
	class digest_scoreboard;
		bit [4:0]     rounds;
		bit [6:0]     digest_len;
		bit [63:0]    salt_lo, salt_hi;
		bit [63:0]    chain[8];
		bit [63:0]    block[16];
		int           fill;
		bit [63:0]    count_lo, count_hi;
		digest_beat_t pending_beats[$];
		int           errors;

		function new();
			rounds = DefaultRounds;
			digest_len = DigestMax;
			salt_lo = '0;
			salt_hi = '0;
			foreach (block[k]) block[k] = '0;
			errors = 0;
			restart();
		endfunction

		function int out_len();
			if (digest_len == 0) return 1;
			if (digest_len > 64) return 64;
			return digest_len;
		endfunction

		function void restart();
			foreach (chain[k]) chain[k] = CHAIN_IV[k];
			chain[0] ^= ParamMix ^ 64'(out_len());
			chain[4] ^= salt_lo;
			chain[5] ^= salt_hi;
			fill = 0;
			count_lo = '0;
			count_hi = '0;
		endfunction

		function bit [63:0] rotr(bit [63:0] x, int n);
			return (x >> n) | (x << (64 - n));
		endfunction

		function void add_bytes(int n);
			bit [64:0] sum;
			sum = {1'b0, count_lo} + 65'(n);
			count_lo = sum[63:0];
			if (sum[64]) count_hi++;
		endfunction

		function void compress(bit [63:0] flag);
			bit [63:0] v[16];
			int nr, row, a, b, c, d;
			nr = (rounds == 0) ? 12 : rounds;
			for (int k = 0; k < 8; k++) begin
				v[k] = chain[k];
				v[k + 8] = CHAIN_IV[k];
			end
			v[12] ^= count_lo;
			v[13] ^= count_hi;
			v[14] ^= flag;
			for (int r = 0; r < nr; r++) begin
				row = r % 10;
				for (int g = 0; g < 8; g++) begin
					a = MIX_LANE[g][0];
					b = MIX_LANE[g][1];
					c = MIX_LANE[g][2];
					d = MIX_LANE[g][3];
					v[a] = v[a] + v[b] + block[MSG_PERM[row][2 * g]];
					v[d] = rotr(v[d] ^ v[a], 32);
					v[c] = v[c] + v[d];
					v[b] = rotr(v[b] ^ v[c], 24);
					v[a] = v[a] + v[b] + block[MSG_PERM[row][2 * g + 1]];
					v[d] = rotr(v[d] ^ v[a], 16);
					v[c] = v[c] + v[d];
					v[b] = rotr(v[b] ^ v[c], 63);
				end
			end
			for (int k = 0; k < 8; k++) chain[k] ^= v[k] ^ v[k + 8];
		endfunction

		function void put_byte(bit [7:0] value);
			block[fill >> 3][(fill & 7) * 8 +: 8] = value;
			fill++;
		endfunction

		function void write_reg(cfg_reg_t idx, bit [63:0] data);
			case (idx)
				CFG_ROUNDS:  rounds = data[4:0];
				CFG_DIGEST:  digest_len = data[6:0];
				CFG_SALT_LO: salt_lo = data;
				CFG_SALT_HI: salt_hi = data;
				default: return;
			endcase
			restart();
		endfunction

		// Absorb one accepted message beat; queue the digest if it ends the message.
		function void note_word(bit [63:0] word, bit [3:0] nbytes, bit last);
			int n, len, beats, vb;
			digest_beat_t beat;
			n = (nbytes > 8) ? 8 : nbytes;
			for (int i = 0; i < n; i++) begin
				if (fill >= 128) begin
					add_bytes(128);
					compress('0);
					fill = 0;
				end
				put_byte(word[8 * i +: 8]);
			end
			if (!last) return;
			add_bytes(fill);
			while (fill < 128) put_byte(8'h00);
			compress(FinalFlag);
			len = out_len();
			beats = (len + 7) / 8;
			for (int i = 0; i < beats; i++) begin
				vb = len - 8 * i;
				if (vb > 8) vb = 8;
				beat.word = chain[i];
				if (vb < 8) beat.word &= (64'd1 << (8 * vb)) - 64'd1;
				beat.nbytes = 4'(vb);
				beat.last = (i + 1 == beats);
				pending_beats.push_back(beat);
			end
			restart();
		endfunction

		function void check_beat(digest_beat_t got);
			digest_beat_t want;
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected digest beat %h/%0d/%0b", $time,
					got.word, got.nbytes, got.last);
				errors++;
				return;
			end
			want = pending_beats.pop_front();
			if (got.word !== want.word) begin
				$display("%0t: digest_word expected %h actual %h", $time,
					want.word, got.word);
				errors++;
			end
			if (got.nbytes !== want.nbytes) begin
				$display("%0t: digest_valid_bytes expected %0d actual %0d", $time,
					want.nbytes, got.nbytes);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_digest_word expected %0b actual %0b", $time,
					want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	b2b_msg_if msg_ch ();
	b2b_dig_if dig_ch ();
	b2b_cfg_if cfg_ch ();

	blake2b_hash_core_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch),
		.cfg    (cfg_ch)
	);

	digest_scoreboard sb = new();

	// Sender state: msg_high mirrors msg_ch.valid so it can be tested before the NBA lands.
	bit msg_high;
	int burst_left;
	int items_sent;
	int ready_pct;
	int ready_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the core hangs.
	initial begin
		#50ms;
		$display("Regression FAIL");
		$finish;
	end

	// Digest receiver: check every accepted beat, then draw ready from a slowly
	// changing acceptance rate so stalls come in stretches of their own.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
			ready_pct = 100;
			ready_hold = 0;
		end else begin
			if (dig_ch.valid && dig_ch.ready)
				sb.check_beat({dig_ch.digest_word, dig_ch.digest_valid_bytes,
					dig_ch.last_digest_word});
			if (ready_hold == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pct = 100;
					1: ready_pct = 70;
					2: ready_pct = 30;
					default: ready_pct = 5;
				endcase
				ready_hold = $urandom_range(10, 80);
			end
			ready_hold--;
			dig_ch.ready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	// Push one message beat; gaps between bursts fall after acceptance.
	task automatic send_word(bit [63:0] word, bit [3:0] nbytes, bit last);
		msg_ch.valid <= 1'b1;
		msg_ch.message_word <= word;
		msg_ch.byte_count <= nbytes;
		msg_ch.final_word <= last;
		msg_high = 1'b1;
		do @(posedge clk); while (!msg_ch.ready);
		sb.note_word(word, nbytes, last);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			msg_ch.valid <= 1'b0;
			msg_high = 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
	endtask

	// Hold off until every owed beat is out, then let any spill compression finish.
	task automatic wait_idle();
		if (msg_high) begin
			msg_ch.valid <= 1'b0;
			msg_high = 1'b0;
			@(posedge clk);
		end
		while (sb.pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Configuration write; only called while the core is idle.
	task automatic write_reg(cfg_reg_t idx, bit [63:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_config();
		if ($urandom_range(0, 1)) begin
			// Keep most round counts small so long messages stay cheap.
			case ($urandom_range(0, 5))
				0: write_reg(CFG_ROUNDS, 64'd0);
				1: write_reg(CFG_ROUNDS, 64'd31);
				default: write_reg(CFG_ROUNDS, 64'($urandom_range(1, 4)));
			endcase
		end
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 7))
				0: write_reg(CFG_DIGEST, 64'd0);
				1: write_reg(CFG_DIGEST, 64'd64);
				2: write_reg(CFG_DIGEST, 64'd65);
				3: write_reg(CFG_DIGEST, 64'd127);
				default: write_reg(CFG_DIGEST, 64'($urandom_range(1, 64)));
			endcase
		end
		if ($urandom_range(0, 2) == 0) write_reg(CFG_SALT_LO, rand64());
		if ($urandom_range(0, 2) == 0) write_reg(CFG_SALT_HI, rand64());
	endtask

	// One message: mostly full words, a few noisy counts, then the closing beat.
	task automatic random_message();
		int nwords;
		nwords = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 14);
		for (int i = 0; i < nwords; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(rand64(), 4'($urandom_range(0, 15)), 1'b0);
			else
				send_word(rand64(), 4'd8, 1'b0);
		end
		send_word(rand64(), 4'($urandom_range(0, 15)), 1'b1);
	endtask

	initial begin
		bit paused;
		arst_n <= 1'b0;
		msg_ch.valid <= 1'b0;
		msg_ch.message_word <= '0;
		msg_ch.byte_count <= '0;
		msg_ch.final_word <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_ROUNDS;
		cfg_ch.data <= '0;
		msg_high = 1'b0;
		burst_left = 8;
		items_sent = 0;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: empty message under reset defaults gives a full 64-byte digest.
		send_word(64'h0, 4'd0, 1'b1);
		// All-ones with an oversized count, a short non-final word, a short final.
		send_word('1, 4'd9, 1'b0);
		send_word(64'h0, 4'd3, 1'b0);
		send_word('1, 4'd5, 1'b1);
		wait_idle();

		// Digest length zero clamps to one byte; maximum rounds.
		write_reg(CFG_DIGEST, 64'd0);
		write_reg(CFG_ROUNDS, 64'd31);
		send_word(64'hA5, 4'd1, 1'b1);
		wait_idle();

		// Oversized digest length clamps to 64; round count zero means twelve.
		// Exactly one block, finalized without any spill.
		write_reg(CFG_DIGEST, 64'd127);
		write_reg(CFG_ROUNDS, 64'd0);
		for (int i = 0; i < 15; i++) send_word(rand64(), 4'd8, 1'b0);
		send_word('1, 4'd15, 1'b1);
		wait_idle();

		// Config write mid-message drops what was buffered.
		write_reg(CFG_SALT_HI, '1);
		send_word(rand64(), 4'd8, 1'b0);
		send_word(rand64(), 4'd8, 1'b0);
		wait_idle();
		write_reg(CFG_SALT_LO, '1);
		send_word(rand64(), 4'd8, 1'b1);

		// Random phase: config changes between messages, one long pause midway.
		while (items_sent < 210) begin
			if ($urandom_range(0, 2) == 0) begin
				wait_idle();
				random_config();
			end
			if (!paused && items_sent > 130) begin
				wait_idle();
				paused = 1'b1;
			end
			random_message();
		end

		if (msg_high) begin
			msg_ch.valid <= 1'b0;
			msg_high = 1'b0;
		end
		while (sb.pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
